@@ rtl/dmul_pkg.sv @@
// Shared types, constants and a helper function for the decimal digit multiplier.
package dmul_pkg;

  localparam int FACTOR_BITS   = 31;
  localparam int DIGIT_W       = 4;
  localparam int FACTOR_DIGITS = 10;
  localparam int BCD_BITS      = FACTOR_DIGITS * DIGIT_W;
  localparam int PRODUCT_DEPTH = 2 * FACTOR_DIGITS;
  localparam int INDEX_W       = $clog2(PRODUCT_DEPTH);
  localparam int COL_W         = 10;
  localparam int CARRY_W       = 7;
  localparam int PROD_W        = 2 * DIGIT_W;

  // Double dabble runs two bits per cycle over the factor padded to an even width.
  localparam int CONV_BITS     = FACTOR_BITS + (FACTOR_BITS % 2);
  localparam int CONV_STEPS    = CONV_BITS / 2;
  localparam int STEP_W        = $clog2(CONV_STEPS);

  // Reciprocal of ten: (x * 205) >> 11 equals x / 10 for every x below 1029.
  localparam int RECIP_MUL     = 205;
  localparam int RECIP_SHIFT   = 11;
  localparam int RECIP_W       = COL_W + 8;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [FACTOR_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

  typedef struct packed {
    bcd_t first_bcd;
    bcd_t second_bcd;
  } item_t;

  // One double dabble step: adjust every digit of five or more, then shift one bit in.
  function automatic bcd_t dd_step(bcd_t v, logic bit_in);
    bcd_t              adj;
    logic [BCD_BITS:0] sh;
    for (int k = 0; k < FACTOR_DIGITS; k++) begin
      adj[k] = (v[k] >= 4'd5) ? v[k] + 4'd3 : v[k];
    end
    sh = {adj, bit_in};
    return sh[BCD_BITS-1:0];
  endfunction

endpackage

@@ rtl/dmul_fifo.sv @@
// Small flop-based queue that decouples the conversion front from the multiply back.
module dmul_fifo #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  // DEPTH must be a power of two so that the pointers wrap on their own.
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/dmul_front.sv @@
// Front end: accepts factor pairs and converts both factors to decimal digits.
module dmul_front
  import dmul_pkg::*;
#(
  parameter int MAX_FACTOR_DIGITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [FACTOR_BITS-1:0] in_first_factor,
  input  logic [FACTOR_BITS-1:0] in_second_factor,
  output logic                   push,
  output item_t                  push_item,
  input  logic                   full
);

  localparam int KEEP_DIGITS =
    (MAX_FACTOR_DIGITS < FACTOR_DIGITS) ? MAX_FACTOR_DIGITS : FACTOR_DIGITS;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CONV = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [CONV_BITS-1:0] bin_a_r, bin_a_nxt;
  logic [CONV_BITS-1:0] bin_b_r, bin_b_nxt;
  bcd_t                 bcd_a_r, bcd_a_nxt;
  bcd_t                 bcd_b_r, bcd_b_nxt;

  assign in_stall = (state_r != F_IDLE);
  assign push     = (state_r == F_PUSH);

  // Digits above the kept width are cleared, which takes each factor modulo a power of ten.
  always_comb begin
    for (int k = 0; k < FACTOR_DIGITS; k++) begin
      push_item.first_bcd[k]  = (k < KEEP_DIGITS) ? bcd_a_r[k] : '0;
      push_item.second_bcd[k] = (k < KEEP_DIGITS) ? bcd_b_r[k] : '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    bin_a_nxt = bin_a_r;
    bin_b_nxt = bin_b_r;
    bcd_a_nxt = bcd_a_r;
    bcd_b_nxt = bcd_b_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          bin_a_nxt = CONV_BITS'(in_first_factor);
          bin_b_nxt = CONV_BITS'(in_second_factor);
          bcd_a_nxt = '0;
          bcd_b_nxt = '0;
          step_nxt  = '0;
          state_nxt = F_CONV;
        end
      end
      F_CONV: begin
        bcd_a_nxt = dd_step(dd_step(bcd_a_r, bin_a_r[CONV_BITS-1]), bin_a_r[CONV_BITS-2]);
        bcd_b_nxt = dd_step(dd_step(bcd_b_r, bin_b_r[CONV_BITS-1]), bin_b_r[CONV_BITS-2]);
        bin_a_nxt = bin_a_r << 2;
        bin_b_nxt = bin_b_r << 2;
        step_nxt  = step_r + 1'b1;
        if (step_r == STEP_W'(CONV_STEPS - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    bin_a_r <= bin_a_nxt;
    bin_b_r <= bin_b_nxt;
    bcd_a_r <= bcd_a_nxt;
    bcd_b_r <= bcd_b_nxt;
  end

endmodule

@@ rtl/dmul_back.sv @@
// Back end: schoolbook digit multiply with a sliding column window, then digit emission.
module dmul_back
  import dmul_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   empty,
  input  item_t  pop_item,
  output logic   pop,
  output logic   out_valid,
  input  logic   out_stall,
  output digit_t out_digit,
  output logic   out_last
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_CALC = 2'd1;
  localparam logic [1:0] B_EMIT = 2'd2;

  logic [1:0]         state_r, state_nxt;
  bcd_t               a_r, a_nxt;
  bcd_t               b_r, b_nxt;
  logic [COL_W-1:0]   acc_r [FACTOR_DIGITS];
  logic [COL_W-1:0]   acc_nxt [FACTOR_DIGITS];
  logic [CARRY_W-1:0] carry_r, carry_nxt;
  logic [INDEX_W-1:0] col_r, col_nxt;
  logic [INDEX_W-1:0] top_r, top_nxt;
  logic [INDEX_W-1:0] emit_r, emit_nxt;
  digit_t             store_r [PRODUCT_DEPTH];
  logic               store_we;

  logic               out_valid_r, out_valid_nxt;
  digit_t             out_digit_r, out_digit_nxt;
  logic               out_last_r, out_last_nxt;

  logic [COL_W-1:0]   sum [FACTOR_DIGITS];
  logic [COL_W-1:0]   total;
  logic [RECIP_W-1:0] recip;
  logic [CARRY_W-1:0] quot;
  logic [COL_W:0]     rem_full;
  digit_t             col_digit;
  logic               load;

  assign out_valid = out_valid_r;
  assign out_digit = out_digit_r;
  assign out_last  = out_last_r;
  assign pop       = (state_r == B_IDLE) && !empty;
  assign load      = (state_r == B_EMIT) && (!out_valid_r || !out_stall);
  assign store_we  = (state_r == B_CALC);

  // One row of partial products enters the window; the lowest column is then complete.
  always_comb begin
    for (int k = 0; k < FACTOR_DIGITS; k++) begin
      sum[k] = acc_r[k] + COL_W'(PROD_W'(a_r[k]) * PROD_W'(b_r[0]));
    end
    total     = sum[0] + COL_W'(carry_r);
    recip     = RECIP_W'(total) * RECIP_W'(RECIP_MUL);
    quot      = recip[RECIP_SHIFT +: CARRY_W];
    rem_full  = (COL_W + 1)'(total) - (COL_W + 1)'(quot) * (COL_W + 1)'(10);
    col_digit = rem_full[DIGIT_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    carry_nxt     = carry_r;
    col_nxt       = col_r;
    top_nxt       = top_r;
    emit_nxt      = emit_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_digit_nxt = out_digit_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      B_IDLE: begin
        if (!empty) begin
          a_nxt     = pop_item.first_bcd;
          b_nxt     = pop_item.second_bcd;
          carry_nxt = '0;
          col_nxt   = '0;
          top_nxt   = '0;
          for (int k = 0; k < FACTOR_DIGITS; k++) begin
            acc_nxt[k] = '0;
          end
          state_nxt = B_CALC;
        end
      end
      B_CALC: begin
        for (int k = 0; k < FACTOR_DIGITS - 1; k++) begin
          acc_nxt[k] = sum[k+1];
        end
        acc_nxt[FACTOR_DIGITS-1] = '0;
        b_nxt     = b_r >> DIGIT_W;
        carry_nxt = quot;
        col_nxt   = col_r + 1'b1;
        if (col_digit != '0) begin
          top_nxt = col_r;
        end
        if (col_r == INDEX_W'(PRODUCT_DEPTH - 1)) begin
          emit_nxt  = top_nxt;
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_digit_nxt = store_r[emit_r];
          out_last_nxt  = (emit_r == '0);
          if (emit_r == '0) begin
            state_nxt = B_IDLE;
          end else begin
            emit_nxt = emit_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    carry_r     <= carry_nxt;
    col_r       <= col_nxt;
    top_r       <= top_nxt;
    emit_r      <= emit_nxt;
    acc_r       <= acc_nxt;
    out_digit_r <= out_digit_nxt;
    out_last_r  <= out_last_nxt;
    if (store_we) begin
      store_r[col_r] <= col_digit;
    end
  end

endmodule

@@ rtl/decimal_digit_multiplier.sv @@
// Top level of the decimal digit multiplier: front converter, item queue, multiply back end.
// The back end takes a new item only after its 20-step column loop and the emission of all
// N = 1..19 product digits, one digit per cycle while the receiver does not stall; the front
// meanwhile converts later pairs into the queue.
// Reset (rst_n low at a clock edge) empties the queue and idles both ends; the digit store
// and datapath registers keep stale values that are always rewritten before use.
module decimal_digit_multiplier
  import dmul_pkg::*;
#(
  parameter int MAX_FACTOR_DIGITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [FACTOR_BITS-1:0] in_first_factor,
  input  logic [FACTOR_BITS-1:0] in_second_factor,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DIGIT_W-1:0]     out_digit,
  output logic                   out_last
);

  // Two entries let the front finish converting the next pair while the back end
  // is still multiplying or emitting, and hold one more pair on top of that.
  localparam int QUEUE_DEPTH = 2;

  logic  q_push, q_full, q_pop, q_empty;
  item_t q_push_item;
  item_t q_pop_item;

  // The front takes one transfer at a time and turns both factors into decimal digits
  // by double dabble, two bits per cycle, trimming them to the kept digit count.
  dmul_front #(
    .MAX_FACTOR_DIGITS(MAX_FACTOR_DIGITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_first_factor  (in_first_factor),
    .in_second_factor (in_second_factor),
    .push             (q_push),
    .push_item        (q_push_item),
    .full             (q_full)
  );

  dmul_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_item),
    .empty     (q_empty)
  );

  // The back end slides a window of column sums across the product: each cycle it adds
  // one row of digit products, settles the lowest column with its carry and stores that
  // digit. It then sends the digits out from the highest nonzero one down.
  dmul_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (q_empty),
    .pop_item  (q_pop_item),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_digit (out_digit),
    .out_last  (out_last)
  );

endmodule

@@ rtl/dmul_checker.sv @@
// Port-level checker for the decimal digit multiplier, bound to its top level.
module dmul_checker
  import dmul_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [DIGIT_W-1:0] out_digit,
  input logic               out_last
);

  logic       first_r;
  logic [2:0] pending_r;
  logic       in_xfer, out_xfer, done_xfer;

  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;
  assign done_xfer = out_xfer && out_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r   <= 1'b1;
      pending_r <= '0;
    end else begin
      if (out_xfer) begin
        first_r <= out_last;
      end
      if (in_xfer && !done_xfer) begin
        pending_r <= pending_r + 1'b1;
      end else if (done_xfer && !in_xfer) begin
        pending_r <= pending_r - 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digit) && $stable(out_last))
    else $error("result changed while stalled");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_digit <= 4'd9)
    else $error("result digit above nine");

  a_no_leading_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && first_r && !out_last |-> out_digit != '0)
    else $error("product starts with a zero digit");

  a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != '0)
    else $error("result without an accepted factor pair");

endmodule

bind decimal_digit_multiplier dmul_checker u_dmul_checker (.*);

@@ tb/decimal_digit_multiplier_tb.sv @@
// Self-checking testbench for the decimal digit multiplier with its own product digit predictor.
module decimal_digit_multiplier_tb
  import dmul_pkg::*;
();

  // The whole run is bounded by this many clock cycles, far more than the slowest correct run
  // takes, with every product at 19 digits, heavy receiver stalls and the long hold-off.
  localparam int CYCLE_LIMIT  = 600000;
  // Length of the receiver hold-off that lets the block fill up and stall its input.
  localparam int HOLD_CYCLES  = 400;
  // Cycles of quiet after the last expected digit.
  localparam int DRAIN_CYCLES = 150;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [FACTOR_BITS-1:0] first_factor;
    logic [FACTOR_BITS-1:0] second_factor;
  } factor_pair_t;

  typedef struct packed {
    digit_t digit;
    logic   last;
  } product_digit_t;

  logic                   clk              = 1'b0;
  logic                   rst_n            = 1'b0;
  logic                   in_valid         = 1'b0;
  logic                   in_stall;
  logic [FACTOR_BITS-1:0] in_first_factor  = '0;
  logic [FACTOR_BITS-1:0] in_second_factor = '0;
  logic                   out_valid;
  logic                   out_stall        = 1'b0;
  logic [DIGIT_W-1:0]     out_digit;
  logic                   out_last;

  // Factor pairs waiting to be offered, and the product digits still owed by the block.
  factor_pair_t   pending_pairs[$];
  product_digit_t owed_digits[$];

  // Idling knobs, in percent per cycle, changed only at a falling edge; then hold-off state.
  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_requests     = 0;
  int unsigned hold_served       = 0;
  int unsigned hold_left         = 0;

  int unsigned cycle_count       = 0;
  int unsigned failures          = 0;
  int unsigned pairs_sent        = 0;
  int unsigned digits_checked    = 0;
  int unsigned products_done     = 0;
  int unsigned input_stall_count = 0;
  int unsigned longest_product   = 0;
  int unsigned digits_in_product = 0;

  // The factor pair currently presented on the input port.
  factor_pair_t offered_pair;

  decimal_digit_multiplier i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_first_factor  (in_first_factor),
    .in_second_factor (in_second_factor),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_digit        (out_digit),
    .out_last         (out_last)
  );

  always #4 clk = ~clk;

  // Only the first few failures are printed in full; the rest are just counted.
  task automatic note_failure(input string what);
    failures++;
    if (failures <= REPORT_MAX) begin
      $display("ERROR at cycle %0d: %s", cycle_count, what);
    end
  endtask

  // Works out the decimal digits of the product, most significant first, and queues them.
  // Each factor keeps only its lowest FACTOR_DIGITS decimal digits, which for 31-bit
  // factors and ten digits never removes anything. A zero product still yields one digit.
  task automatic queue_product_digits(input factor_pair_t pair);
    longint unsigned digit_limit;
    longint unsigned first_val;
    longint unsigned second_val;
    longint unsigned product;
    digit_t          column_digit[PRODUCT_DEPTH];
    int              width;
    product_digit_t  entry;
    digit_limit = 1;
    for (int k = 0; k < FACTOR_DIGITS; k++) begin
      digit_limit = digit_limit * 10;
    end
    first_val  = longint'(pair.first_factor) % digit_limit;
    second_val = longint'(pair.second_factor) % digit_limit;
    product    = first_val * second_val;
    for (int k = 0; k < PRODUCT_DEPTH; k++) begin
      column_digit[k] = digit_t'(product % 10);
      product         = product / 10;
    end
    width = PRODUCT_DEPTH;
    while (width > 1 && column_digit[width-1] == '0) begin
      width--;
    end
    for (int k = width - 1; k >= 0; k--) begin
      entry.digit = column_digit[k];
      entry.last  = (k == 0);
      owed_digits.push_back(entry);
    end
  endtask

  // Picks a factor from a mix of shapes: zero, full random words, short numbers of a random
  // digit count, powers of ten, runs of nines and values near the top of the range.
  function automatic logic [FACTOR_BITS-1:0] pick_factor();
    logic [FACTOR_BITS-1:0] value;
    longint unsigned        bound;
    int unsigned            ndig;
    bound = 1;
    ndig  = $urandom_range(FACTOR_DIGITS, 1);
    for (int k = 0; k < ndig; k++) begin
      bound = bound * 10;
    end
    case ($urandom_range(9))
      0: begin
        value = '0;
      end
      1, 2, 3: begin
        value = FACTOR_BITS'($urandom);
      end
      4, 5, 6: begin
        value = FACTOR_BITS'(longint'($urandom) % bound);
      end
      7: begin
        value = (ndig < FACTOR_DIGITS) ? FACTOR_BITS'(bound / 10) : FACTOR_BITS'(1);
      end
      8: begin
        value = (ndig < FACTOR_DIGITS) ? FACTOR_BITS'(bound - 1) : '1;
      end
      default: begin
        value = '1 - FACTOR_BITS'($urandom_range(3));
      end
    endcase
    return value;
  endfunction

  // Driver. A new pair is offered only when the port is free: nothing presented, or the
  // presented pair was transferred at this edge. A stalled pair stays as it is.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_stall) begin
        input_stall_count++;
      end
      if (!in_valid || !in_stall) begin
        if (in_valid) begin
          // The presented pair has been transferred; its digits are now owed.
          queue_product_digits(offered_pair);
          pairs_sent++;
        end
        if (pending_pairs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          offered_pair      = pending_pairs.pop_front();
          in_valid         <= 1'b1;
          in_first_factor  <= offered_pair.first_factor;
          in_second_factor <= offered_pair.second_factor;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall. A requested hold-off keeps stall high for a long, counted stretch;
  // otherwise stall follows the random stall rate of the current phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Monitor. Every transferred digit is matched against the oldest owed digit.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (owed_digits.size() == 0) begin
        note_failure($sformatf("digit %0d last %0b arrived with nothing owed",
                               out_digit, out_last));
      end else begin
        if (out_digit !== owed_digits[0].digit || out_last !== owed_digits[0].last) begin
          note_failure($sformatf("expected digit %0d last %0b, got digit %0d last %0b",
                                 owed_digits[0].digit, owed_digits[0].last,
                                 out_digit, out_last));
        end
        void'(owed_digits.pop_front());
      end
      digits_checked++;
      digits_in_product++;
      if (out_last === 1'b1) begin
        products_done++;
        if (digits_in_product > longest_product) begin
          longest_product = digits_in_product;
        end
        digits_in_product = 0;
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d pairs pending and %0d digits owed",
               cycle_count, pending_pairs.size(), owed_digits.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic add_pair(input logic [FACTOR_BITS-1:0] a, input logic [FACTOR_BITS-1:0] b);
    factor_pair_t pair;
    pair.first_factor  = a;
    pair.second_factor = b;
    pending_pairs.push_back(pair);
  endtask

  // Waits until every queued pair has been transferred and every owed digit has arrived.
  task automatic wait_until_idle();
    while (pending_pairs.size() > 0 || in_valid || owed_digits.size() > 0) begin
      @(negedge clk);
    end
  endtask

  // One phase of random traffic under the given idling rates.
  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned count);
    @(negedge clk);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int k = 0; k < count; k++) begin
      add_pair(pick_factor(), pick_factor());
    end
    wait_until_idle();
  endtask

  initial begin
    // Synchronous reset, held from time zero and released at a rising edge.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed pairs: zero products, single-digit products, trailing zeros, the largest
    // factors, the longest products, and alternating bit patterns.
    add_pair(0, 0);
    add_pair(0, '1);
    add_pair('1, 0);
    add_pair(1, 1);
    add_pair(1, 0);
    add_pair(9, 1);
    add_pair(9, 9);
    add_pair(5, 2);
    add_pair(10, 10);
    add_pair(100000, 7);
    add_pair('1, 1);
    add_pair('1, '1);
    add_pair(999999999, 999999999);
    add_pair(1000000000, 1000000000);
    add_pair(2000000000, 2000000000);
    add_pair(99999, 99999);
    add_pair(123456789, 987654321);
    add_pair(31'h4000_0000, 31'h4000_0000);
    add_pair(31'h5555_5555, 31'h2AAA_AAAA);
    add_pair(31'h2AAA_AAAA, 31'h5555_5555);
    add_pair('1, 31'h4000_0000);
    wait_until_idle();

    // Random traffic: no idling, sender idle, receiver stalling, then both together.
    run_phase(0, 0, 100);
    run_phase(73, 0, 100);
    run_phase(0, 73, 100);
    run_phase(34, 34, 100);

    // Back-pressure: the receiver holds off for a long stretch while the sender keeps
    // offering pairs, so the block fills up and stalls its input.
    @(negedge clk);
    hold_requests++;
    run_phase(0, 0, 40);

    // Let the block settle, then make sure nothing further comes out.
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (owed_digits.size() > 0) begin
      note_failure($sformatf("%0d product digits never arrived", owed_digits.size()));
    end

    $display("Covered %0d factor pairs and %0d product digits (longest product %0d digits)",
             pairs_sent, digits_checked, longest_product);
    $display("over five idling phases, with %0d cycles of input back-pressure seen.",
             input_stall_count);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures in total", failures);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
